/* rtl/core/cpf_pkg.sv */
// ============================================================================
// cpf_pkg
// Shared types and codes for the command parameter framer.
// ============================================================================
`default_nettype none

package cpf_pkg;

    localparam int CODE_W    = 3;   // bits per signature slot
    localparam int CNT_W     = 5;   // per-type counter width
    localparam int NUM_TYPES = 5;   // byte, int16, int32, string, blob
    localparam int OFF_W     = 12;  // reported buffer offset width

    // signature slot codes
    localparam logic [CODE_W-1:0] CODE_END    = 3'd0;
    localparam logic [CODE_W-1:0] CODE_BYTE   = 3'd1;
    localparam logic [CODE_W-1:0] CODE_INT16  = 3'd2;
    localparam logic [CODE_W-1:0] CODE_INT32  = 3'd3;
    localparam logic [CODE_W-1:0] CODE_STRING = 3'd4;
    localparam logic [CODE_W-1:0] CODE_BLOB   = 3'd5;

    // reported parameter types
    localparam logic [2:0] PT_BYTE   = 3'd0;
    localparam logic [2:0] PT_INT16  = 3'd1;
    localparam logic [2:0] PT_INT32  = 3'd2;
    localparam logic [2:0] PT_STRING = 3'd3;
    localparam logic [2:0] PT_BLOB   = 3'd4;

    // error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_BAD_CODE = 2'd1;
    localparam logic [1:0] ERR_BUF_FULL = 2'd2;
    localparam logic [1:0] ERR_TOO_MANY = 2'd3;

    // request kinds
    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_TABLE = 1'b1;

    typedef enum logic [2:0] {
        MODE_NEW,
        MODE_FIXED,
        MODE_STRING,
        MODE_LEN_LO,
        MODE_LEN_HI
    } mode_t;

    typedef struct packed {
        logic              kind;
        logic [7:0]        data_byte;
        logic [7:0]        table_cmd;
        logic [2:0]        table_slot;
        logic [CODE_W-1:0] table_code;
    } item_t;

    typedef struct packed {
        logic             more_expected;
        logic             stored;
        logic [OFF_W-1:0] store_offset;
        logic             param_started;
        logic [2:0]       param_type;
        logic [3:0]       param_index;
        logic [OFF_W-1:0] param_offset;
        logic [15:0]      blob_length;
        logic [1:0]       error;
    } result_t;

    // signature slot write, already range checked
    typedef struct packed {
        logic              en;
        logic [7:0]        cmd;
        logic [2:0]        slot;
        logic [CODE_W-1:0] code;
    } sig_wr_t;

    typedef logic [NUM_TYPES-1:0][CNT_W-1:0] cnt_arr_t;

endpackage

`default_nettype wire

/* rtl/core/cpf_sig_mem.sv */
// ============================================================================
// cpf_sig_mem
// Signature table: one row per command, two registered read ports, slot
// write, per-row valid bits, write-to-read forwarding.
// ============================================================================
`default_nettype none

module cpf_sig_mem
    import cpf_pkg::*;
#(
    parameter int SIG_SLOTS = 8,
    parameter int NUM_CMDS  = 256
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        rd_en,
    input  wire logic [7:0]                  rd_cmd_a,
    input  wire logic [7:0]                  rd_cmd_b,
    input  wire sig_wr_t                     wr,
    output logic      [CODE_W*SIG_SLOTS-1:0] row_a,
    output logic      [CODE_W*SIG_SLOTS-1:0] row_b
);

    localparam int ROW_W  = CODE_W * SIG_SLOTS;
    localparam int CMD_AW = (NUM_CMDS > 1) ? $clog2(NUM_CMDS) : 1;
    localparam logic [8:0] NCMD = 9'(NUM_CMDS);

    logic [ROW_W-1:0]    mem [NUM_CMDS];
    logic [NUM_CMDS-1:0] row_vld_reg;

    logic [ROW_W-1:0]  data_a_reg;
    logic [ROW_W-1:0]  data_b_reg;
    logic              vld_a_reg;
    logic              vld_b_reg;
    logic [7:0]        cmd_a_reg;
    logic [7:0]        cmd_b_reg;
    logic              fwd_en_reg;
    logic [7:0]        fwd_cmd_reg;
    logic [2:0]        fwd_slot_reg;
    logic [CODE_W-1:0] fwd_code_reg;

    logic [ROW_W-1:0]  fresh_row;
    logic [CMD_AW-1:0] wr_idx;
    logic [CMD_AW-1:0] rd_idx_a;
    logic [CMD_AW-1:0] rd_idx_b;
    logic              in_rng_a;
    logic              in_rng_b;
    logic              hit_a;
    logic              hit_b;

    assign wr_idx   = wr.cmd[CMD_AW-1:0];
    assign rd_idx_a = rd_cmd_a[CMD_AW-1:0];
    assign rd_idx_b = rd_cmd_b[CMD_AW-1:0];
    assign in_rng_a = {1'b0, rd_cmd_a} < NCMD;
    assign in_rng_b = {1'b0, rd_cmd_b} < NCMD;

    // row written into an entry never touched since reset: other slots end
    always_comb
    begin
        for (int j = 0; j < SIG_SLOTS; j++)
        begin
            fresh_row[CODE_W*j +: CODE_W] = (32'(wr.slot) == j) ? wr.code : CODE_END;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            if (row_vld_reg[wr_idx])
            begin
                mem[wr_idx][CODE_W*wr.slot +: CODE_W] <= wr.code;
            end
            else
            begin
                mem[wr_idx] <= fresh_row;
            end
        end
        if (rd_en)
        begin
            data_a_reg   <= mem[rd_idx_a];
            data_b_reg   <= mem[rd_idx_b];
            cmd_a_reg    <= rd_cmd_a;
            cmd_b_reg    <= rd_cmd_b;
            fwd_cmd_reg  <= wr.cmd;
            fwd_slot_reg <= wr.slot;
            fwd_code_reg <= wr.code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg <= '0;
            vld_a_reg   <= 1'b0;
            vld_b_reg   <= 1'b0;
            fwd_en_reg  <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                row_vld_reg[wr_idx] <= 1'b1;
            end
            if (rd_en)
            begin
                vld_a_reg  <= in_rng_a && row_vld_reg[rd_idx_a];
                vld_b_reg  <= in_rng_b && row_vld_reg[rd_idx_b];
                fwd_en_reg <= wr.en;
            end
        end
    end

    // a write landing on the same edge as the read is patched in here
    assign hit_a = fwd_en_reg && (fwd_cmd_reg == cmd_a_reg);
    assign hit_b = fwd_en_reg && (fwd_cmd_reg == cmd_b_reg);

    always_comb
    begin
        row_a = vld_a_reg ? data_a_reg : '0;
        row_b = vld_b_reg ? data_b_reg : '0;
        for (int j = 0; j < SIG_SLOTS; j++)
        begin
            if (hit_a && (32'(fwd_slot_reg) == j))
            begin
                row_a[CODE_W*j +: CODE_W] = fwd_code_reg;
            end
            if (hit_b && (32'(fwd_slot_reg) == j))
            begin
                row_b[CODE_W*j +: CODE_W] = fwd_code_reg;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/cpf_frame.sv */
// ============================================================================
// cpf_frame
// Framing state and per-request step: byte storage, parameter starts,
// slot advance, error flags and signature write requests.
// ============================================================================
`default_nettype none

module cpf_frame
    import cpf_pkg::*;
#(
    parameter int SIG_SLOTS    = 8,
    parameter int RECV_BYTES   = 4096,
    parameter int MAX_PER_TYPE = 16,
    parameter int NUM_CMDS     = 256
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        step,
    input  wire item_t                       item,
    input  wire logic [CODE_W*SIG_SLOTS-1:0] row_a,
    input  wire logic [CODE_W*SIG_SLOTS-1:0] row_b,
    output result_t                          res,
    output sig_wr_t                          wr,
    output logic      [7:0]                  cmd_ahead
);

    localparam int ROW_W = CODE_W * SIG_SLOTS;
    localparam int SPW   = $clog2(SIG_SLOTS + 1);
    localparam int WPW   = $clog2(RECV_BYTES + 1);
    localparam logic [8:0]       NCMD  = 9'(NUM_CMDS);
    localparam logic [4:0]       NSLOT = 5'(SIG_SLOTS);
    localparam logic [SPW-1:0]   SLOTS = SPW'(SIG_SLOTS);
    localparam logic [WPW-1:0]   RBYTE = WPW'(RECV_BYTES);
    localparam logic [CNT_W-1:0] MAXPT = CNT_W'(MAX_PER_TYPE);

    mode_t          mode_reg,  mode_next;
    logic [7:0]     cmd_reg,   cmd_next;
    logic [SPW-1:0] slot_reg,  slot_next;
    logic [15:0]    rem_reg,   rem_next;
    logic [7:0]     llb_reg,   llb_next;
    logic [WPW-1:0] wp_reg,    wp_next;
    cnt_arr_t       cnt_reg,   cnt_next;

    logic [ROW_W-1:0]  row;
    logic [CODE_W-1:0] code;
    logic [2:0]        pt;
    logic [15:0]       len;
    logic              do_slot;
    logic              do_end;

    assign row = (mode_reg == MODE_NEW) ? row_a : row_b;

    always_comb
    begin
        mode_next = mode_reg;
        cmd_next  = cmd_reg;
        slot_next = slot_reg;
        rem_next  = rem_reg;
        llb_next  = llb_reg;
        wp_next   = wp_reg;
        cnt_next  = cnt_reg;
        res       = '0;
        wr        = '0;
        code      = CODE_END;
        pt        = PT_BYTE;
        len       = {item.data_byte, llb_reg};
        do_slot   = 1'b0;
        do_end    = 1'b0;

        if (item.kind == KIND_TABLE)
        begin
            // table is written only when the request actually steps
            wr.en   = step && ({1'b0, item.table_cmd} < NCMD) &&
                      ({2'b00, item.table_slot} < NSLOT);
            wr.cmd  = item.table_cmd;
            wr.slot = item.table_slot;
            wr.code = item.table_code;
            res.more_expected = (mode_reg != MODE_NEW);
        end
        else
        begin
            // byte storage for fixed and string fields
            if (mode_reg == MODE_FIXED || mode_reg == MODE_STRING)
            begin
                if (wp_next < RBYTE)
                begin
                    res.stored       = 1'b1;
                    res.store_offset = OFF_W'(wp_next);
                    wp_next          = wp_next + 1'b1;
                end
                else if (res.error == ERR_NONE)
                begin
                    res.error = ERR_BUF_FULL;
                end
            end

            case (mode_reg)
                MODE_FIXED:
                begin
                    rem_next = rem_next - 16'd1;
                    res.more_expected = 1'b1;
                    do_slot = (rem_next == 16'd0);
                end
                MODE_STRING:
                begin
                    res.more_expected = 1'b1;
                    do_slot = (item.data_byte == 8'd0);
                end
                MODE_LEN_LO:
                begin
                    llb_next  = item.data_byte;
                    mode_next = MODE_LEN_HI;
                    res.more_expected = 1'b1;
                end
                MODE_LEN_HI:
                begin
                    // blob start
                    if (cnt_next[PT_BLOB] >= MAXPT)
                    begin
                        if (res.error == ERR_NONE)
                        begin
                            res.error = ERR_TOO_MANY;
                        end
                    end
                    else
                    begin
                        res.param_started = 1'b1;
                        res.param_type    = PT_BLOB;
                        res.param_index   = cnt_next[PT_BLOB][3:0];
                        res.param_offset  = OFF_W'(wp_next);
                        res.blob_length   = len;
                        cnt_next[PT_BLOB] = cnt_next[PT_BLOB] + 1'b1;
                    end
                    if (len == 16'd0)
                    begin
                        do_slot = 1'b1;
                    end
                    else
                    begin
                        rem_next  = len;
                        mode_next = MODE_FIXED;
                        res.more_expected = 1'b1;
                    end
                end
                default:
                begin
                    cmd_next  = item.data_byte;
                    slot_next = '0;
                    do_slot   = 1'b1;
                end
            endcase

            // open the next signature slot
            if (do_slot)
            begin
                if (slot_next < SLOTS)
                begin
                    code = CODE_W'(row >> (CODE_W * slot_next));
                end
                pt = code - 3'd1;
                res.more_expected = 1'b1;
                if (code == CODE_END)
                begin
                    do_end = 1'b1;
                    res.more_expected = 1'b0;
                end
                else
                begin
                    slot_next = slot_next + 1'b1;
                    case (code)
                        CODE_BYTE, CODE_INT16, CODE_INT32, CODE_STRING:
                        begin
                            if (cnt_next[pt] >= MAXPT)
                            begin
                                if (res.error == ERR_NONE)
                                begin
                                    res.error = ERR_TOO_MANY;
                                end
                            end
                            else
                            begin
                                if (!res.param_started)
                                begin
                                    res.param_started = 1'b1;
                                    res.param_type    = pt;
                                    res.param_index   = cnt_next[pt][3:0];
                                    res.param_offset  = OFF_W'(wp_next);
                                end
                                cnt_next[pt] = cnt_next[pt] + 1'b1;
                            end
                            if (code == CODE_STRING)
                            begin
                                mode_next = MODE_STRING;
                            end
                            else
                            begin
                                mode_next = MODE_FIXED;
                                rem_next  = (code == CODE_BYTE)  ? 16'd1 :
                                            (code == CODE_INT16) ? 16'd2 : 16'd4;
                            end
                        end
                        CODE_BLOB:
                        begin
                            mode_next = MODE_LEN_LO;
                        end
                        default:
                        begin
                            if (res.error == ERR_NONE)
                            begin
                                res.error = ERR_BAD_CODE;
                            end
                            do_end = 1'b1;
                            res.more_expected = 1'b0;
                        end
                    endcase
                end
            end

            // command complete or aborted
            if (do_end)
            begin
                mode_next = MODE_NEW;
                slot_next = '0;
                rem_next  = '0;
                llb_next  = '0;
                wp_next   = '0;
                cnt_next  = '0;
            end
        end
    end

    assign cmd_ahead = step ? cmd_next : cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NEW;
            cmd_reg  <= '0;
            slot_reg <= '0;
            rem_reg  <= '0;
            llb_reg  <= '0;
            wp_reg   <= '0;
            cnt_reg  <= '0;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            cmd_reg  <= cmd_next;
            slot_reg <= slot_next;
            rem_reg  <= rem_next;
            llb_reg  <= llb_next;
            wp_reg   <= wp_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/command_parameter_framer_top.sv */
// ============================================================================
// command_parameter_framer_top
// Stage 1 holds each accepted request while its table row is read; the output
// register then takes its result. Throughput: one request per cycle while the
// result side keeps up, set by the single table read and framing step per cycle.
// Reset: asynchronous, clears the framing state and the table row valid bits
// at once (table reads as all end codes); no clearing pass is needed.
// ============================================================================
`default_nettype none

module command_parameter_framer_top
    import cpf_pkg::*;
#(
    parameter int SIG_SLOTS    = 8,
    parameter int RECV_BYTES   = 4096,
    parameter int MAX_PER_TYPE = 16,
    parameter int NUM_CMDS     = 256
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input request stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // s_tdata, low bit up: data_byte[7:0], table_cmd[15:8], table_slot[18:16],
    // table_code[21:19], zero pad[23:22]
    input  wire logic [23:0] s_tdata,
    // s_tuser: kind[0] (0 data byte, 1 signature table write)
    input  wire logic [0:0]  s_tuser,
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tdata, low bit up: more_expected[0], stored[1], store_offset[13:2],
    // param_started[14], param_type[17:15], param_index[21:18],
    // param_offset[33:22], blob_length[49:34], error[51:50], zero pad[55:52]
    output logic      [55:0] m_tdata
);

    localparam int ROW_W = CODE_W * SIG_SLOTS;

    // stage 1 holds the accepted request while its table row is read
    logic    s1_valid_reg;
    item_t   s1_item_reg;
    logic    out_valid_reg;
    result_t out_res_reg;

    logic             step;
    logic             rd_en;
    item_t            in_item;
    result_t          res;
    sig_wr_t          wr;
    logic [7:0]       cmd_ahead;
    logic [ROW_W-1:0] row_a;
    logic [ROW_W-1:0] row_b;

    assign in_item.kind       = s_tuser[0];
    assign in_item.data_byte  = s_tdata[7:0];
    assign in_item.table_cmd  = s_tdata[15:8];
    assign in_item.table_slot = s_tdata[18:16];
    assign in_item.table_code = s_tdata[21:19];

    // stage 1 advances when the output register is free or draining
    assign step     = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || step;
    assign rd_en    = s_tvalid && s_tready;

    // port A: row of a possible command byte; port B: row of the command
    // in progress after the current step
    cpf_sig_mem #(
        .SIG_SLOTS (SIG_SLOTS),
        .NUM_CMDS  (NUM_CMDS)
    ) u_sig_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_cmd_a (in_item.data_byte),
        .rd_cmd_b (cmd_ahead),
        .wr       (wr),
        .row_a    (row_a),
        .row_b    (row_b)
    );

    cpf_frame #(
        .SIG_SLOTS    (SIG_SLOTS),
        .RECV_BYTES   (RECV_BYTES),
        .MAX_PER_TYPE (MAX_PER_TYPE),
        .NUM_CMDS     (NUM_CMDS)
    ) u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .item      (s1_item_reg),
        .row_a     (row_a),
        .row_b     (row_b),
        .res       (res),
        .wr        (wr),
        .cmd_ahead (cmd_ahead)
    );

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            s1_item_reg <= in_item;
        end
        if (step)
        begin
            out_res_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (step)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0,
                       out_res_reg.error,
                       out_res_reg.blob_length,
                       out_res_reg.param_offset,
                       out_res_reg.param_index,
                       out_res_reg.param_type,
                       out_res_reg.param_started,
                       out_res_reg.store_offset,
                       out_res_reg.stored,
                       out_res_reg.more_expected};

endmodule

`default_nettype wire

/* tb/sv/command_parameter_framer_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// command_parameter_framer_checker
// Watches both streams of the framer, predicts the framing result of every
// accepted request and compares each returned result with the oldest one due.
// ============================================================================

module command_parameter_framer_checker
    import cpf_pkg::*;
#(
    parameter int SIG_SLOTS    = 8,
    parameter int RECV_BYTES   = 4096,
    parameter int MAX_PER_TYPE = 16,
    parameter int NUM_CMDS     = 256
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [23:0] s_tdata,
    input  wire logic [0:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [55:0] m_tdata,
    output int               mismatch_count,
    output int               framing_due_count
);

    localparam int REPORT_LIMIT = 10;

    // framer state as seen from outside
    logic [SIG_SLOTS*CODE_W-1:0] sig_rows [NUM_CMDS];
    mode_t                       mode;
    logic [7:0]                  cur_cmd;
    logic [4:0]                  slot_pos;
    logic [15:0]                 remaining;
    logic [7:0]                  len_lo;
    int                          wr_ptr;
    logic [CNT_W-1:0]            type_cnt [NUM_TYPES];

    result_t framing_due [$];

    function automatic void flag_error(inout result_t r, input logic [1:0] err);
        if (r.error == ERR_NONE)
            r.error = err;
    endfunction

    function automatic void close_command();
        mode      = MODE_NEW;
        slot_pos  = '0;
        remaining = '0;
        len_lo    = '0;
        wr_ptr    = 0;
        foreach (type_cnt[i])
            type_cnt[i] = '0;
    endfunction

    // records a parameter start; true when it is the one reported
    function automatic logic open_param(inout result_t r, input logic [2:0] ptype);
        logic shown;
        shown = 1'b0;
        if (type_cnt[ptype] >= MAX_PER_TYPE) begin
            flag_error(r, ERR_TOO_MANY);
            return 1'b0;
        end
        if (!r.param_started) begin
            r.param_started = 1'b1;
            r.param_type    = ptype;
            r.param_index   = type_cnt[ptype][3:0];
            r.param_offset  = wr_ptr[OFF_W-1:0];
            shown           = 1'b1;
        end
        type_cnt[ptype] = type_cnt[ptype] + 1'b1;
        return shown;
    endfunction

    function automatic void store_byte(inout result_t r);
        if (wr_ptr < RECV_BYTES) begin
            r.stored       = 1'b1;
            r.store_offset = wr_ptr[OFF_W-1:0];
            wr_ptr++;
        end else begin
            flag_error(r, ERR_BUF_FULL);
        end
    endfunction

    // opens the next signature slot; returns whether the command goes on
    function automatic logic advance_slot(inout result_t r);
        logic [CODE_W-1:0] code;
        code = CODE_END;
        if (slot_pos < SIG_SLOTS && cur_cmd < NUM_CMDS)
            code = sig_rows[cur_cmd][slot_pos*CODE_W +: CODE_W];
        if (code == CODE_END) begin
            close_command();
            return 1'b0;
        end
        slot_pos = slot_pos + 1'b1;
        case (code)
            CODE_BYTE:   begin void'(open_param(r, PT_BYTE));   remaining = 16'd1; mode = MODE_FIXED; end
            CODE_INT16:  begin void'(open_param(r, PT_INT16));  remaining = 16'd2; mode = MODE_FIXED; end
            CODE_INT32:  begin void'(open_param(r, PT_INT32));  remaining = 16'd4; mode = MODE_FIXED; end
            CODE_STRING: begin void'(open_param(r, PT_STRING)); mode = MODE_STRING; end
            CODE_BLOB:   mode = MODE_LEN_LO;
            default:
            begin
                flag_error(r, ERR_BAD_CODE);
                close_command();
                return 1'b0;
            end
        endcase
        return 1'b1;
    endfunction

    function automatic result_t frame_request(input logic kind, input logic [23:0] data);
        result_t     r;
        logic [7:0]  b;
        logic [15:0] blen;
        logic        more;
        int          c;
        int          s;
        r = '0;
        if (kind == KIND_TABLE) begin
            c = int'(data[15:8]);
            s = int'(data[18:16]);
            if (c < NUM_CMDS && s < SIG_SLOTS)
                sig_rows[c][s*CODE_W +: CODE_W] = data[21:19];
            r.more_expected = (mode != MODE_NEW);
            return r;
        end
        b = data[7:0];
        case (mode)
            MODE_FIXED:
            begin
                store_byte(r);
                remaining = remaining - 1'b1;
                if (remaining == 0)
                    more = advance_slot(r);
                else
                    more = 1'b1;
            end
            MODE_STRING:
            begin
                store_byte(r);
                if (b == 8'h00)
                    more = advance_slot(r);
                else
                    more = 1'b1;
            end
            MODE_LEN_LO:
            begin
                len_lo = b;
                mode   = MODE_LEN_HI;
                more   = 1'b1;
            end
            MODE_LEN_HI:
            begin
                blen = {b, len_lo};
                if (open_param(r, PT_BLOB))
                    r.blob_length = blen;
                // an empty blob closes at once and opens the next slot
                if (blen == 0) begin
                    more = advance_slot(r);
                end else begin
                    remaining = blen;
                    mode      = MODE_FIXED;
                    more      = 1'b1;
                end
            end
            default:
            begin
                cur_cmd  = b;
                slot_pos = '0;
                more     = advance_slot(r);
            end
        endcase
        r.more_expected = more;
        return r;
    endfunction

    always @(posedge clk) begin
        result_t got;
        result_t want;
        string   diff;
        if (!rst_n) begin
            foreach (sig_rows[i])
                sig_rows[i] = '0;
            cur_cmd = '0;
            close_command();
            framing_due.delete();
            mismatch_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got               = '0;
                got.more_expected = m_tdata[0];
                got.stored        = m_tdata[1];
                got.store_offset  = m_tdata[13:2];
                got.param_started = m_tdata[14];
                got.param_type    = m_tdata[17:15];
                got.param_index   = m_tdata[21:18];
                got.param_offset  = m_tdata[33:22];
                got.blob_length   = m_tdata[49:34];
                got.error         = m_tdata[51:50];
                if (framing_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: result with none due, tdata %h", $time, m_tdata);
                end else begin
                    want = framing_due.pop_front();
                    diff = "";
                    if (got.more_expected !== want.more_expected)
                        diff = {diff, $sformatf(" more_expected %0d/%0d",
                                                want.more_expected, got.more_expected)};
                    if (got.stored !== want.stored)
                        diff = {diff, $sformatf(" stored %0d/%0d", want.stored, got.stored)};
                    if (got.store_offset !== want.store_offset)
                        diff = {diff, $sformatf(" store_offset %0d/%0d",
                                                want.store_offset, got.store_offset)};
                    if (got.param_started !== want.param_started)
                        diff = {diff, $sformatf(" param_started %0d/%0d",
                                                want.param_started, got.param_started)};
                    if (got.param_type !== want.param_type)
                        diff = {diff, $sformatf(" param_type %0d/%0d",
                                                want.param_type, got.param_type)};
                    if (got.param_index !== want.param_index)
                        diff = {diff, $sformatf(" param_index %0d/%0d",
                                                want.param_index, got.param_index)};
                    if (got.param_offset !== want.param_offset)
                        diff = {diff, $sformatf(" param_offset %0d/%0d",
                                                want.param_offset, got.param_offset)};
                    if (got.blob_length !== want.blob_length)
                        diff = {diff, $sformatf(" blob_length %0d/%0d",
                                                want.blob_length, got.blob_length)};
                    if (got.error !== want.error)
                        diff = {diff, $sformatf(" error %0d/%0d", want.error, got.error)};
                    if (diff != "") begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("%0t: result mismatch (expected/actual):%s", $time, diff);
                    end
                end
            end
            if (s_tvalid && s_tready)
                framing_due.push_back(frame_request(s_tuser[0], s_tdata));
        end
        framing_due_count = framing_due.size();
    end

endmodule

/* tb/sv/command_parameter_framer_top_test.sv */
`timescale 1ns / 1ps
// ============================================================================
// command_parameter_framer_top_test
// Drives host bytes and signature writes into the framer: a directed opening,
// a command that uses every slot of its signature, then random commands
// framed from a shadow of the signature table under several idle and stall
// mixes. The checker beside the block predicts and compares every result.
// ============================================================================

module command_parameter_framer_top_test;
    import cpf_pkg::*;

    localparam int SIG_SLOTS    = 8;
    localparam int RECV_BYTES   = 4096;
    localparam int MAX_PER_TYPE = 16;
    localparam int NUM_CMDS     = 256;

    // watchdog bound on the run; keep a wide margin
    localparam int CYCLE_LIMIT  = 100000;
    localparam int HOLD_CYCLES  = 300;    // receiver hold-off during the fill test
    localparam int PHASE_ITEMS  = 90;     // random requests per idle/stall mix
    localparam int FILL_ITEMS   = 40;     // requests offered during the hold-off
    localparam int POOL_SIZE    = 6;      // commands that get full random signatures
    localparam int FULL_BLOB    = 3;      // blob length in the full-signature command
    localparam int SETTLE       = 10;     // cycles watched for stray results at the end

    // codes the block must reject; the package only names the valid ones
    localparam logic [CODE_W-1:0] CODE_BAD_LO = 3'd6;
    localparam logic [CODE_W-1:0] CODE_BAD_HI = 3'd7;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;

    int mismatch_count;
    int framing_due_count;

    int   cycle_count        = 0;
    int   sent_count         = 0;
    int   sender_idle_pct    = 0;
    int   receiver_stall_pct = 0;
    logic hold_req           = 1'b0;

    // what the stimulus believes the signature table holds, so that it can
    // build commands the block will frame all the way through
    logic [CODE_W-1:0] shadow_sig [NUM_CMDS][SIG_SLOTS];
    logic [7:0]        cmd_pool   [POOL_SIZE];

    command_parameter_framer_top #(
        .SIG_SLOTS    (SIG_SLOTS),
        .RECV_BYTES   (RECV_BYTES),
        .MAX_PER_TYPE (MAX_PER_TYPE),
        .NUM_CMDS     (NUM_CMDS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    command_parameter_framer_checker #(
        .SIG_SLOTS    (SIG_SLOTS),
        .RECV_BYTES   (RECV_BYTES),
        .MAX_PER_TYPE (MAX_PER_TYPE),
        .NUM_CMDS     (NUM_CMDS)
    ) u_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .s_tuser           (s_tuser),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .mismatch_count    (mismatch_count),
        .framing_due_count (framing_due_count)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** command_parameter_framer_top: FAILED **");
            $finish;
        end
    end

    // Result side. Random stalls at the current rate, except for one long
    // hold-off, counted here, that starts once hold_req goes high.
    int   hold_left  = 0;
    logic hold_taken = 1'b0;

    always @(negedge clk) begin
        if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // One request, entered and left at a falling edge. Idle cycles come first,
    // so valid is only lowered when a gap is actually inserted.
    task automatic send_request(input logic kind, input logic [23:0] payload);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= payload;
        s_tuser  <= kind;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent_count++;
        @(negedge clk);
    endtask

    // host byte; the table fields are don't-care here and get random bits
    task automatic send_byte(input logic [7:0] b);
        logic [13:0] filler;
        filler = 14'($urandom);
        send_request(KIND_DATA, {2'b00, filler, b});
    endtask

    task automatic write_sig(input logic [7:0] cmd, input logic [2:0] slot,
                             input logic [CODE_W-1:0] code);
        logic [7:0] filler;
        filler                = 8'($urandom);
        shadow_sig[cmd][slot] = code;
        send_request(KIND_TABLE, {2'b00, code, slot, cmd, filler});
    endtask

    // sender stops and waits until every result due has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (framing_due_count != 0)
            @(negedge clk);
    endtask

    // mostly valid codes, some end codes, a few invalid ones
    function automatic logic [CODE_W-1:0] pick_code();
        int r;
        r = $urandom_range(99);
        if (r < 4)
            return $urandom_range(1) ? CODE_BAD_HI : CODE_BAD_LO;
        if (r < 14)
            return CODE_END;
        return CODE_W'($urandom_range(CODE_BYTE, CODE_BLOB));
    endfunction

    // Sends a command and its parameters as the shadow signature says. The
    // slot is read before any signature write that is slipped in, so that the
    // block and the stimulus see the same code. A broken command is cut short
    // and followed by a few stray bytes.
    task automatic send_command(input logic [7:0] cmd, input bit broken);
        int                slot;
        int                len;
        bit                done;
        logic [CODE_W-1:0] code;
        send_byte(cmd);
        slot = 0;
        done = 0;
        while (!done && slot < SIG_SLOTS) begin
            if (broken && $urandom_range(2) == 0) begin
                repeat ($urandom_range(1, 3))
                    send_byte(8'($urandom_range(255)));
                done = 1;
            end else begin
                code = shadow_sig[cmd][slot];
                slot++;
                // table write while the command is in progress
                if ($urandom_range(19) == 0)
                    write_sig(cmd, 3'($urandom_range(SIG_SLOTS - 1)), pick_code());
                case (code)
                    CODE_BYTE:
                        send_byte(8'($urandom_range(255)));
                    CODE_INT16:
                        repeat (2) send_byte(8'($urandom_range(255)));
                    CODE_INT32:
                        repeat (4) send_byte(8'($urandom_range(255)));
                    CODE_STRING:
                    begin
                        repeat ($urandom_range(0, 5))
                            send_byte(8'($urandom_range(1, 255)));
                        send_byte(8'h00);
                    end
                    CODE_BLOB:
                    begin
                        // zero length included; rarely a length past 255
                        len = ($urandom_range(39) == 0) ? $urandom_range(256, 272)
                                                        : $urandom_range(0, 5);
                        send_byte(len[7:0]);
                        send_byte(len[15:8]);
                        repeat (len)
                            send_byte(8'($urandom_range(255)));
                    end
                    default:
                        done = 1;   // end code, or an invalid code that aborts
                endcase
            end
        end
    endtask

    task automatic random_request_mix(input int count);
        int target;
        int r;
        target = sent_count + count;
        while (sent_count < target) begin
            r = $urandom_range(99);
            if (r < 10)
                write_sig(($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                   : cmd_pool[$urandom_range(POOL_SIZE - 1)],
                          3'($urandom_range(SIG_SLOTS - 1)), pick_code());
            else if (r < 18)
                repeat ($urandom_range(1, 4))
                    send_byte(8'($urandom_range(255)));
            else
                send_command(cmd_pool[$urandom_range(POOL_SIZE - 1)],
                             $urandom_range(9) == 0);
        end
    endtask

    initial begin
        int len;
        foreach (shadow_sig[c, s])
            shadow_sig[c][s] = CODE_END;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---- directed ----
        // empty signatures after reset: commands end on their first byte
        send_byte(8'h00);
        send_byte(8'hFF);

        // one of each parameter type, then an empty blob and a byte behind it
        write_sig(8'h10, 3'd0, CODE_BYTE);
        write_sig(8'h10, 3'd1, CODE_INT16);
        write_sig(8'h10, 3'd2, CODE_INT32);
        write_sig(8'h10, 3'd3, CODE_STRING);
        write_sig(8'h10, 3'd4, CODE_BLOB);
        write_sig(8'h10, 3'd5, CODE_BLOB);
        write_sig(8'h10, 3'd6, CODE_BYTE);
        send_byte(8'h10);
        send_byte(8'hFF);                       // byte
        send_byte(8'h00); send_byte(8'hFF);     // int16
        send_byte(8'h01); send_byte(8'h80);     // int32
        send_byte(8'h7F); send_byte(8'hFE);
        send_byte(8'h41); send_byte(8'h00);     // string "A"
        send_byte(8'h02); send_byte(8'h00);     // blob, two bytes
        send_byte(8'hAA); send_byte(8'h55);
        send_byte(8'h00); send_byte(8'h00);     // empty blob opens the byte slot
        send_byte(8'h5A);                       // that byte; command completes

        // invalid code aborts the command
        write_sig(8'h00, 3'd0, CODE_BAD_LO);
        send_byte(8'h00);
        write_sig(8'hFF, 3'd7, CODE_END);
        drain();

        // ---- full signature ----
        // a short blob then seven byte slots; the command ends after the last
        // slot with no end code
        write_sig(8'h20, 3'd0, CODE_BLOB);
        for (int s = 1; s < SIG_SLOTS; s++)
            write_sig(8'h20, s[2:0], CODE_BYTE);
        len = FULL_BLOB;
        send_byte(8'h20);
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        repeat (FULL_BLOB)
            send_byte(8'($urandom_range(255)));
        repeat (SIG_SLOTS - 1)
            send_byte(8'($urandom_range(255)));
        send_byte(8'h20);   // next command right after the full signature
        drain();

        // ---- random ----
        // give a pool of commands random signatures of random length
        for (int p = 0; p < POOL_SIZE; p++) begin
            cmd_pool[p] = 8'($urandom_range(255));
            len         = $urandom_range(0, SIG_SLOTS);
            for (int s = 0; s < SIG_SLOTS; s++)
                write_sig(cmd_pool[p], s[2:0],
                          (s < len) ? CODE_W'($urandom_range(CODE_BYTE, CODE_BLOB))
                                    : CODE_END);
        end

        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        random_request_mix(PHASE_ITEMS);
        drain();

        sender_idle_pct = 65;
        random_request_mix(PHASE_ITEMS);
        drain();

        sender_idle_pct    = 0;
        receiver_stall_pct <= 65;
        random_request_mix(PHASE_ITEMS);
        drain();

        sender_idle_pct    = 14;
        receiver_stall_pct <= 14;
        random_request_mix(PHASE_ITEMS);
        drain();

        // ---- back-pressure ----
        // result side holds off while requests keep coming, so the block
        // fills and drops s_tready
        sender_idle_pct    = 0;
        receiver_stall_pct <= 0;
        hold_req           <= 1'b1;
        random_request_mix(FILL_ITEMS);
        drain();

        // watch a little longer for results that nobody asked for
        repeat (SETTLE) @(negedge clk);
        if (mismatch_count == 0)
            $display("** command_parameter_framer_top: PASSED **");
        else
            $display("** command_parameter_framer_top: FAILED **");
        $finish;
    end

endmodule
